// ===== design/hsnl_pkg.sv =====
// Shared constants, types and helpers for the hexagonal sheet neighbor list block.
package hsnl_pkg;

    localparam int SIDE_W   = 11;   // width of the rows/cols registers
    localparam int ROW_W    = 10;
    localparam int COL_W    = 11;
    localparam int IDX_W    = 21;   // node index width
    localparam int CNT_W    = 3;
    localparam int RING_N   = 6;
    localparam int SLOT_W   = 3;
    localparam int MAX_SIDE = 1024;
    localparam int MIN_SIDE = 2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    // ring order: down-left, down-right, right, up-right, up, left
    typedef struct packed {
        logic [SLOT_W-1:0] start;
        logic [CNT_W-1:0]  count;
    } t_ring_sel;

    // (start + step) mod 6, both below 6
    function automatic logic [SLOT_W-1:0] ring_slot(input logic [SLOT_W-1:0] start,
                                                    input logic [SLOT_W-1:0] step);
        logic [SLOT_W:0] sum;
        sum = {1'b0, start} + {1'b0, step};
        if (sum >= (SLOT_W+1)'(RING_N)) begin
            sum = sum - (SLOT_W+1)'(RING_N);
        end
        return sum[SLOT_W-1:0];
    endfunction

endpackage

// ===== design/hsnl_req_if.sv =====
// Request channel: one node position per item.
interface hsnl_req_if;
    import hsnl_pkg::*;

    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;

    modport source (output valid, output row, output col, input ready);
    modport sink   (input valid, input row, input col, output ready);
endinterface

// ===== design/hsnl_rsp_if.sv =====
// Response channel: node index, neighbor ring and status flags per item.
interface hsnl_rsp_if;
    import hsnl_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] node_index;
    logic [IDX_W-1:0] neighbor_a;
    logic [IDX_W-1:0] neighbor_b;
    logic [IDX_W-1:0] neighbor_c;
    logic [IDX_W-1:0] neighbor_d;
    logic [IDX_W-1:0] neighbor_e;
    logic [IDX_W-1:0] neighbor_f;
    logic [CNT_W-1:0] neighbor_count;
    logic             incomplete_loop;
    logic             bad_position;

    modport source (output valid, output node_index,
                    output neighbor_a, output neighbor_b, output neighbor_c,
                    output neighbor_d, output neighbor_e, output neighbor_f,
                    output neighbor_count, output incomplete_loop, output bad_position,
                    input ready);
    modport sink   (input valid, input node_index,
                    input neighbor_a, input neighbor_b, input neighbor_c,
                    input neighbor_d, input neighbor_e, input neighbor_f,
                    input neighbor_count, input incomplete_loop, input bad_position,
                    output ready);
endinterface

// ===== design/hsnl_ring.sv =====
// Picks the start slot and length of the contiguous run of present ring slots.
module hsnl_ring (
    input  logic [hsnl_pkg::RING_N-1:0] i_present,
    output hsnl_pkg::t_ring_sel         o_sel
);
    import hsnl_pkg::*;

    logic [SLOT_W-1:0] start;
    logic [CNT_W-1:0]  count;
    logic [SLOT_W:0]   k;
    logic              chain;
    logic              run;
    logic [SLOT_W-1:0] slot;

    always_comb begin
        start = '0;
        count = '0;
        k     = (SLOT_W+1)'(RING_N);
        chain = 1'b1;
        run   = 1'b1;
        slot  = '0;
        if (&i_present) begin
            start = '0;
        end else if (i_present[0]) begin
            // back up over the run that wraps into slot 0
            for (int i = RING_N - 1; i >= 1; i--) begin
                if (chain && i_present[i]) begin
                    k = (SLOT_W+1)'(i);
                end else begin
                    chain = 1'b0;
                end
            end
            start = (k == (SLOT_W+1)'(RING_N)) ? '0 : k[SLOT_W-1:0];
        end else begin
            for (int i = RING_N - 1; i >= 1; i--) begin
                if (i_present[i]) begin
                    start = SLOT_W'(i);
                end
            end
        end
        for (int i = 0; i < RING_N; i++) begin
            slot = ring_slot(start, SLOT_W'(i));
            if (run && i_present[slot]) begin
                count = count + CNT_W'(1);
            end else begin
                run = 1'b0;
            end
        end
        o_sel.start = start;
        o_sel.count = count;
    end
endmodule

// ===== design/hex_sheet_neighbor_list.sv =====
// Hexagonal sheet neighbor list: top level.
//
// Usage: rows and cols are set through the write port (i_cfg_we, i_cfg_idx,
// i_cfg_data) while the block is idle; values below 2 act as 2 and above
// the sheet maximum act as the maximum. Each item on i_req carries a node
// position (row, col); o_rsp returns one item with the node index, up to
// six neighbor indices in ring order, their count, an incomplete flag for
// boundary nodes and a bad-position flag (all other fields zero then).
// An item accepted on i_req is registered, worked on in one pass of
// combinational logic (a 10x11 multiply and adders) and registered again
// for o_rsp. Throughput: one item per cycle unless o_rsp is stalled.
// When o_rsp is stalled the result register holds the item and the input
// register can still take one more; i_req.ready drops only when both are
// full. Reset clears both valid flags and sets rows and cols to 2.
module hex_sheet_neighbor_list (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hsnl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hsnl_pkg::SIDE_W-1:0]     i_cfg_data,
    hsnl_req_if.sink                        i_req,
    hsnl_rsp_if.source                      o_rsp
);
    import hsnl_pkg::*;

    logic [SIDE_W-1:0] r_rows;
    logic [SIDE_W-1:0] r_cols;

    logic              r_s1_valid;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;

    logic              r_s2_valid;
    logic [IDX_W-1:0]  r_node_index;
    logic [IDX_W-1:0]  r_nb [RING_N];
    logic [CNT_W-1:0]  r_count;
    logic              r_incomplete;
    logic              r_bad;

    logic              s2_load;
    logic              s1_load;

    logic [SIDE_W-1:0] ny;
    logic [SIDE_W-1:0] nx;
    logic [SIDE_W:0]   len;
    logic [SIDE_W:0]   last;
    logic              odd;
    logic              top_row;
    logic              bot_row;
    logic              first_col;
    logic              last_col;
    logic              bad;
    logic [IDX_W-1:0]  nxe;
    logic [IDX_W-1:0]  base;
    logic [IDX_W-1:0]  nb [RING_N];
    logic [RING_N-1:0] present;
    t_ring_sel         sel;
    logic [IDX_W-1:0]  n_node_index;
    logic [IDX_W-1:0]  n_nb [RING_N];
    logic [CNT_W-1:0]  n_count;
    logic              n_incomplete;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] res;
        res = v;
        if (v < SIDE_W'(MIN_SIDE)) begin
            res = SIDE_W'(MIN_SIDE);
        end else if (32'(v) > MAX_SIDE) begin
            res = SIDE_W'(MAX_SIDE);
        end
        return res;
    endfunction

    assign s2_load     = r_s1_valid && (!r_s2_valid || o_rsp.ready);
    assign s1_load     = i_req.valid && i_req.ready;
    assign i_req.ready = !r_s1_valid || s2_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= SIDE_W'(MIN_SIDE);
            r_cols <= SIDE_W'(MIN_SIDE);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROWS: r_rows <= i_cfg_data;
                CFG_COLS: r_cols <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= 1'b1;
        end else if (s2_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_row <= i_req.row;
            r_col <= i_req.col;
        end
    end

    // geometry of the requested node
    always_comb begin
        ny        = clamp_side(r_rows);
        nx        = clamp_side(r_cols);
        odd       = r_row[0];
        len       = {1'b0, nx} + (SIDE_W+1)'(odd);
        last      = len - (SIDE_W+1)'(1);
        bad       = ({1'b0, r_row} >= ny) || ({1'b0, r_col} >= len);
        top_row   = (r_row == '0);
        bot_row   = ({1'b0, r_row} == ny - SIDE_W'(1));
        first_col = (r_col == '0);
        last_col  = ({1'b0, r_col} == last);

        nxe  = IDX_W'(nx);
        base = IDX_W'(r_row) * nxe + IDX_W'(r_row >> 1) + IDX_W'(r_col);

        nb[0] = base - nxe - IDX_W'(1);
        nb[1] = base - nxe;
        nb[2] = base + IDX_W'(1);
        nb[3] = base + nxe + IDX_W'(1);
        nb[4] = base + nxe;
        nb[5] = base - IDX_W'(1);

        present[0] = !top_row && !(first_col && odd);
        present[1] = !top_row && !(last_col && odd);
        present[2] = !last_col;
        present[3] = !bot_row && !(last_col && odd);
        present[4] = !bot_row && !(first_col && odd);
        present[5] = !first_col;
    end

    hsnl_ring u_ring (
        .i_present (present),
        .o_sel     (sel)
    );

    always_comb begin
        n_node_index = bad ? '0 : base;
        n_count      = bad ? '0 : sel.count;
        n_incomplete = !bad && (sel.count < CNT_W'(RING_N));
        for (int i = 0; i < RING_N; i++) begin
            if (!bad && (CNT_W'(i) < sel.count)) begin
                n_nb[i] = nb[ring_slot(sel.start, SLOT_W'(i))];
            end else begin
                n_nb[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_load) begin
            r_s2_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_node_index <= n_node_index;
            r_nb         <= n_nb;
            r_count      <= n_count;
            r_incomplete <= n_incomplete;
            r_bad        <= bad;
        end
    end

    assign o_rsp.valid           = r_s2_valid;
    assign o_rsp.node_index      = r_node_index;
    assign o_rsp.neighbor_a      = r_nb[0];
    assign o_rsp.neighbor_b      = r_nb[1];
    assign o_rsp.neighbor_c      = r_nb[2];
    assign o_rsp.neighbor_d      = r_nb[3];
    assign o_rsp.neighbor_e      = r_nb[4];
    assign o_rsp.neighbor_f      = r_nb[5];
    assign o_rsp.neighbor_count  = r_count;
    assign o_rsp.incomplete_loop = r_incomplete;
    assign o_rsp.bad_position    = r_bad;

endmodule

// ===== dv/hex_sheet_neighbor_list_test.sv =====
// Self-checking testbench for the hexagonal sheet neighbor list block.
`timescale 1ns / 100ps

module hex_sheet_neighbor_list_test;
    import hsnl_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]              node_index;
        logic [RING_N-1:0][IDX_W-1:0]  nbr;
        logic [CNT_W-1:0]              nbr_count;
        logic                          incomplete;
        logic                          bad_pos;
    } t_node_nbrs;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [SIDE_W-1:0]    i_cfg_data;

    hsnl_req_if req_ch ();
    hsnl_rsp_if rsp_ch ();

    hex_sheet_neighbor_list uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the sheet registers, raw written bits
    logic [SIDE_W-1:0] sheet_rows = SIDE_W'(2);
    logic [SIDE_W-1:0] sheet_cols = SIDE_W'(2);

    t_node_nbrs pending_nbrs[$];
    int         mismatch_count = 0;
    int         src_idle_pct = 0;
    int         snk_stall_pct = 0;
    int         hold_off_cycles = 0;

    function automatic int clamp_side(input logic [SIDE_W-1:0] v);
        if (v < SIDE_W'(MIN_SIDE)) return MIN_SIDE;
        if (v > SIDE_W'(MAX_SIDE)) return MAX_SIDE;
        return int'(v);
    endfunction

    function automatic t_node_nbrs predict_nbrs(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
        t_node_nbrs res;
        int ny, nx, r, c, row_len, base, cnt, k, j;
        int off[RING_N];
        int ring[RING_N];
        bit on_border;
        res = '0;
        ny = clamp_side(sheet_rows);
        nx = clamp_side(sheet_cols);
        r = int'(row);
        c = int'(col);
        row_len = nx + (r % 2);
        if (r >= ny || c >= row_len) begin
            res.bad_pos = 1'b1;
            return res;
        end
        base = r * nx + r / 2 + c;
        // down-left, down-right, right, up-right, up, left
        off[0] = -nx - 1; off[1] = -nx; off[2] = 1;
        off[3] = nx + 1;  off[4] = nx;  off[5] = -1;
        for (j = 0; j < RING_N; j++) ring[j] = 0;
        cnt = 0;
        on_border = (c == 0 || c == row_len - 1 || r == 0 || r == ny - 1);
        if (on_border) begin
            if (r == 0) begin off[0] = 0; off[1] = 0; end
            if (r == ny - 1) begin off[3] = 0; off[4] = 0; end
            if (c == 0) begin
                off[5] = 0;
                if (r % 2 == 1) begin off[0] = 0; off[4] = 0; end
            end
            if (c == row_len - 1) begin
                off[2] = 0;
                if (r % 2 == 1) begin off[1] = 0; off[3] = 0; end
            end
            // one contiguous run of present slots, starting after a gap
            if (off[0] != 0) begin
                k = 6;
                while (k > 1 && off[k-1] != 0) k--;
                for (j = k; j < 6; j++) begin ring[cnt] = base + off[j]; cnt++; end
                for (j = 0; j < k && off[j] != 0; j++) begin
                    ring[cnt] = base + off[j];
                    cnt++;
                end
            end else begin
                k = 1;
                while (k < 6 && off[k] == 0) k++;
                while (k < 6 && off[k] != 0) begin
                    ring[cnt] = base + off[k];
                    cnt++;
                    k++;
                end
            end
        end else begin
            for (j = 0; j < RING_N; j++) ring[j] = base + off[j];
            cnt = 6;
        end
        res.node_index = IDX_W'(base);
        for (j = 0; j < cnt; j++) res.nbr[j] = IDX_W'(ring[j]);
        res.nbr_count  = CNT_W'(cnt);
        res.incomplete = (cnt < 6);
        return res;
    endfunction

    // receiver: random stalls plus an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_off_cycles = hold_off_cycles - 1;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic note_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
    endtask

    always @(posedge i_clk) begin : check_results
        t_node_nbrs want, got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.node_index = rsp_ch.node_index;
            got.nbr        = {rsp_ch.neighbor_f, rsp_ch.neighbor_e, rsp_ch.neighbor_d,
                              rsp_ch.neighbor_c, rsp_ch.neighbor_b, rsp_ch.neighbor_a};
            got.nbr_count  = rsp_ch.neighbor_count;
            got.incomplete = rsp_ch.incomplete_loop;
            got.bad_pos    = rsp_ch.bad_position;
            if (pending_nbrs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with no item outstanding, node_index %0d",
                             $realtime, got.node_index);
            end else begin
                want = pending_nbrs.pop_front();
                if (got.node_index !== want.node_index)
                    note_mismatch("node_index", want.node_index, got.node_index);
                for (int i = 0; i < RING_N; i++) begin
                    if (got.nbr[i] !== want.nbr[i])
                        note_mismatch($sformatf("neighbor %0d", i), want.nbr[i], got.nbr[i]);
                end
                if (got.nbr_count !== want.nbr_count)
                    note_mismatch("neighbor_count", want.nbr_count, got.nbr_count);
                if (got.incomplete !== want.incomplete)
                    note_mismatch("incomplete_loop", want.incomplete, got.incomplete);
                if (got.bad_pos !== want.bad_pos)
                    note_mismatch("bad_position", want.bad_pos, got.bad_pos);
            end
        end
    end

    // entered and left just after a falling edge
    task automatic send_node(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.row   <= row;
        req_ch.col   <= col;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_nbrs.push_back(predict_nbrs(row, col));
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending_nbrs.size() != 0);
    endtask

    task automatic set_sheet(input logic [SIDE_W-1:0] n_rows, input logic [SIDE_W-1:0] n_cols);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ROWS;
        i_cfg_data <= n_rows;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_COLS;
        i_cfg_data <= n_cols;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sheet_rows = n_rows;
        sheet_cols = n_cols;
    endtask

    function automatic logic [SIDE_W-1:0] pick_side();
        case ($urandom_range(9))
            0:       return SIDE_W'(MAX_SIDE);
            1:       return SIDE_W'($urandom_range(1, 0));
            2:       return SIDE_W'($urandom_range(2047, MAX_SIDE + 1));
            3:       return SIDE_W'($urandom_range(MAX_SIDE, MIN_SIDE));
            default: return SIDE_W'($urandom_range(12, MIN_SIDE));
        endcase
    endfunction

    // biased toward borders and corners; some off-sheet and raw noise
    task automatic send_random_node();
        int ny, nx, r, c, row_len;
        ny = clamp_side(sheet_rows);
        nx = clamp_side(sheet_cols);
        case ($urandom_range(9))
            0:       r = 0;
            1:       r = ny - 1;
            2:       r = $urandom_range(1023);
            default: r = $urandom_range(ny - 1);
        endcase
        row_len = nx + (r % 2);
        case ($urandom_range(9))
            0:       c = 0;
            1:       c = row_len - 1;
            2:       c = row_len;
            3:       c = $urandom_range(2047);
            default: c = $urandom_range(row_len - 1);
        endcase
        send_node(ROW_W'(r), COL_W'(c));
    endtask

    task automatic test_reset_sheet();
        // reset leaves a 2x2 sheet: rows of 2 and 3 nodes
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (r < 2 || c == 0) send_node(ROW_W'(r), COL_W'(c));
            end
        end
        send_node(ROW_W'(1023), COL_W'(2047));
        wait_for_results();
    endtask

    task automatic test_largest_sheet();
        set_sheet(SIDE_W'(MAX_SIDE), SIDE_W'(MAX_SIDE));
        send_node(ROW_W'(0), COL_W'(0));
        send_node(ROW_W'(0), COL_W'(1023));
        send_node(ROW_W'(0), COL_W'(1024));
        send_node(ROW_W'(1), COL_W'(0));
        send_node(ROW_W'(1), COL_W'(1024));
        send_node(ROW_W'(1), COL_W'(1025));
        send_node(ROW_W'(1022), COL_W'(1023));
        send_node(ROW_W'(1023), COL_W'(0));
        send_node(ROW_W'(1023), COL_W'(1024));
        send_node(ROW_W'(1023), COL_W'(1025));
        send_node(ROW_W'(511), COL_W'(500));
        wait_for_results();
    endtask

    task automatic test_register_clamp();
        set_sheet(SIDE_W'(0), SIDE_W'(1));
        repeat (8) send_random_node();
        wait_for_results();
        set_sheet(SIDE_W'(2047), SIDE_W'(1500));
        repeat (8) send_random_node();
        wait_for_results();
    endtask

    task automatic test_random_sheets(input int idle_pct, input int stall_pct);
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        repeat (4) begin
            set_sheet(pick_side(), pick_side());
            repeat (84) send_random_node();
            wait_for_results();
        end
        src_idle_pct  = 0;
        snk_stall_pct = 0;
    endtask

    task automatic test_output_hold_off();
        set_sheet(SIDE_W'(7), SIDE_W'(5));
        hold_off_cycles = 200;
        repeat (60) send_random_node();
        wait_for_results();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_ROWS;
        i_cfg_data   = '0;
        req_ch.valid = 1'b0;
        req_ch.row   = '0;
        req_ch.col   = '0;
        rsp_ch.ready = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_sheet();
        test_largest_sheet();
        test_register_clamp();
        test_random_sheets(0, 0);
        test_random_sheets(77, 0);
        test_random_sheets(0, 77);
        test_random_sheets(15, 15);
        test_output_hold_off();

        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
